// ----- src/escape_time_fold_fractal_pixel_assert.svh -----
// Assertion macros used by the checker of the fold-map pixel block.
`ifndef ESCAPE_TIME_FOLD_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FOLD_FRACTAL_PIXEL_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and idle while i_rst_n is low.
`define ETFF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and idle while i_rst_n is low.
`define ETFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/etff_pkg.sv -----
// ----------------------------------------------------------------------------
// Fold-map pixel package
// Shared types, fixed-point constants, register indexes and the palette
// functions that are evaluated while the design is elaborated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etff_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd4;

    localparam logic signed [35:0] Q_ONE  = 36'sd16777216;
    localparam logic signed [35:0] Q_HALF = 36'sd8388608;
    localparam logic signed [31:0] ESC_LIMIT = 32'sd18454938;

    localparam logic [23:0] COLOUR_WHITE = 24'hFFFFFF;
    localparam logic [23:0] COLOUR_BLACK = 24'h000000;

    localparam logic [63:0] F_ONE        = 64'h0400000000000000;
    localparam logic [63:0] F_TWO_PI     = 64'h1921FB54442D1847;
    localparam logic [63:0] F_HALF_PI    = 64'h06487ED5110B4612;
    localparam logic [63:0] F_QUARTER_PI = 64'h03243F6A8885A309;

    typedef struct packed {
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic [9:0]         x;
        logic [9:0]         y;
    } t_point;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic signed [31:0] etff_sat46(input logic signed [45:0] v);
        logic signed [31:0] res;
        if (v > 46'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -46'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] etff_sat36(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [63:0] etff_mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[121:58];
    endfunction

    function automatic logic signed [63:0] etff_trig125(input logic [12:0] n, input int d,
                                                        input bit want_sin);
        logic [63:0]        m, r, t, u, u2, term, c, s, mag, hi, lo, tmp;
        logic signed [63:0] cs, ss, v;
        int                 i, k, q;
        m = F_TWO_PI * 64'(d);
        r = 64'd0;
        q = 0;
        for (i = 12; i >= 0; i--) begin
            r = r << 1;
            if (r >= m) r = r - m;
            if (n[i]) begin
                r = r + F_ONE;
                if (r >= m) r = r - m;
            end
        end
        case (d)
            1: t = r;
            2: t = r >> 1;
            default: t = r / 64'd3;
        endcase
        for (k = 0; k < 3; k++) begin
            if (t >= F_HALF_PI) begin
                t = t - F_HALF_PI;
                q = q + 1;
            end
        end
        u = (t > F_QUARTER_PI) ? ((t > F_HALF_PI) ? 64'd0 : F_HALF_PI - t) : t;
        u2 = etff_mulq(u, u);
        c = F_ONE;
        term = F_ONE;
        for (k = 1; k <= 12; k++) begin
            term = etff_mulq(term, u2) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) c = c - term; else c = c + term;
        end
        s = u;
        term = u;
        for (k = 1; k <= 12; k++) begin
            term = etff_mulq(term, u2) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) s = s - term; else s = s + term;
        end
        if (t > F_QUARTER_PI) begin
            tmp = c;
            c = s;
            s = tmp;
        end
        case (q)
            0: begin cs = c;  ss = s;  end
            1: begin cs = -s; ss = c;  end
            2: begin cs = -c; ss = -s; end
            default: begin cs = s; ss = -c; end
        endcase
        v = want_sin ? ss : cs;
        mag = v[63] ? -v : v;
        hi = mag >> 32;
        lo = mag & 64'hFFFFFFFF;
        mag = ((hi * 64'd125) + ((lo * 64'd125) >> 32)) >> 26;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [23:0] etff_palette(input logic [12:0] n);
        logic [63:0] red, green, blue, rgb;
        red   = 64'd125 - etff_trig125(n, 1, 1'b0);
        green = 64'd125 + etff_trig125(n, 2, 1'b1);
        blue  = 64'd125 + etff_trig125(n, 3, 1'b0);
        rgb   = (red << 16) + (green << 8) + blue;
        return rgb[23:0];
    endfunction

endpackage

// ----- src/escape_time_fold_fractal_pixel.sv -----
// A pixel beat is scaled about the image centre in the cycle it is accepted
// and the product is registered; its start point is then panned, saturated
// and pushed into a two-entry queue when the queue has room, so the front end
// keeps taking pixels while the iteration engine is busy, up to a full queue.
// The iteration engine applies one fold step per cycle: it takes the start
// point from the queue, runs the fold loop until it stops after n steps and
// loads the output register once that is free. n is at most the smaller of
// max_iterations and ITER_LIMIT, so throughput is set by that single fold
// loop. Results leave through an output register; the user must write
// configuration only while the block holds no pixel; it is not enforced.
// ----------------------------------------------------------------------------
// Fold-map escape-time pixel colouring
// Maps a pixel to a Q8.24 start point, iterates the folding map and returns
// the palette colour together with the pixel position and the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escape_time_fold_fractal_pixel import etff_pkg::*; #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024,
    parameter int ITER_LIMIT   = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [9:0]           i_pixel_x,
    input  logic [9:0]           i_pixel_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [23:0]          o_colour,
    output logic [9:0]           o_out_x,
    output logic [9:0]           o_out_y,
    output logic [8:0]           o_iteration_count
);

    localparam int CW   = $clog2(ITER_LIMIT + 1);
    localparam int LIMW = (CW > 9) ? CW : 9;

    logic [8:0]         r_max_iter;
    logic [30:0]        r_scale_x, r_scale_y;
    logic signed [31:0] r_offset_x, r_offset_y;
    logic [CW-1:0]      w_limit;
    logic               w_push, w_pop;
    t_point             w_push_pt, w_pop_pt;
    t_q_status          w_q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= 9'd64;
            r_scale_x  <= 31'd16384;
            r_scale_y  <= 31'd16384;
            r_offset_x <= 32'sd0;
            r_offset_y <= 32'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[8:0];
                CFG_SCALE_X:  r_scale_x  <= i_cfg_data[30:0];
                CFG_SCALE_Y:  r_scale_y  <= i_cfg_data[30:0];
                CFG_OFFSET_X: r_offset_x <= i_cfg_data;
                CFG_OFFSET_Y: r_offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (LIMW'(r_max_iter) > LIMW'(ITER_LIMIT)) begin
            w_limit = CW'(ITER_LIMIT);
        end else begin
            w_limit = CW'(r_max_iter);
        end
    end

    etff_front #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_scale_x (r_scale_x),
        .i_scale_y (r_scale_y),
        .i_offset_x(r_offset_x),
        .i_offset_y(r_offset_y),
        .i_q_status(w_q_status),
        .o_push    (w_push),
        .o_point   (w_push_pt)
    );

    etff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_pt),
        .i_pop   (w_pop),
        .o_data  (w_pop_pt),
        .o_status(w_q_status)
    );

    etff_back #(
        .ITER_LIMIT(ITER_LIMIT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_status       (w_q_status),
        .i_point          (w_pop_pt),
        .o_pop            (w_pop),
        .i_limit          (w_limit),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_colour         (o_colour),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_iteration_count(o_iteration_count)
    );

endmodule

// ----- src/etff_front.sv -----
// ----------------------------------------------------------------------------
// Fold-map pixel front end
// Accepts pixel beats, scales them about the image centre and adds the pan,
// then pushes the saturated Q8.24 start point into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etff_front import etff_pkg::*; #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [9:0]         i_pixel_x,
    input  logic [9:0]         i_pixel_y,
    input  logic [30:0]        i_scale_x,
    input  logic [30:0]        i_scale_y,
    input  logic signed [31:0] i_offset_x,
    input  logic signed [31:0] i_offset_y,
    input  t_q_status          i_q_status,
    output logic               o_push,
    output t_point             o_point
);

    localparam logic signed [12:0] CENTRE_X = 13'(IMAGE_WIDTH / 2);
    localparam logic signed [12:0] CENTRE_Y = 13'(IMAGE_HEIGHT / 2);

    logic               r_v;
    logic signed [44:0] r_prod_x, r_prod_y;
    logic [9:0]         r_x, r_y;
    logic signed [12:0] w_dx, w_dy;

    assign w_dx    = $signed({3'b000, i_pixel_x}) - CENTRE_X;
    assign w_dy    = $signed({3'b000, i_pixel_y}) - CENTRE_Y;
    assign o_stall = r_v && i_q_status.full;
    assign o_push  = r_v && !i_q_status.full;

    always_comb begin
        o_point.zr = etff_sat46(46'(r_prod_x) + 46'(i_offset_x));
        o_point.zi = etff_sat46(46'(r_prod_y) + 46'(i_offset_y));
        o_point.x  = r_x;
        o_point.y  = r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_prod_x <= w_dx * $signed({1'b0, i_scale_x});
            r_prod_y <= w_dy * $signed({1'b0, i_scale_y});
            r_x      <= i_pixel_x;
            r_y      <= i_pixel_y;
        end
    end

endmodule

// ----- src/etff_queue.sv -----
// ----------------------------------------------------------------------------
// Fold-map pixel start-point queue
// Two-entry register queue that lets the front end and the iteration engine
// stall independently of each other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etff_queue import etff_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_point    i_data,
    input  logic      i_pop,
    output t_point    o_data,
    output t_q_status o_status
);

    logic       r_wr, r_rd;
    logic [1:0] r_count;
    t_point     r_mem [2];

    assign o_data          = r_mem[r_rd];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ----- src/etff_back.sv -----
// ----------------------------------------------------------------------------
// Fold-map pixel iteration engine
// Runs one fold step a cycle until the limit or escape, takes the colour from
// white, black or the palette table and holds the beat in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etff_back import etff_pkg::*; #(
    parameter int ITER_LIMIT = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_q_status                            i_q_status,
    input  t_point                               i_point,
    output logic                                 o_pop,
    input  logic [$clog2(ITER_LIMIT + 1)-1:0]    i_limit,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [23:0]                          o_colour,
    output logic [9:0]                           o_out_x,
    output logic [9:0]                           o_out_y,
    output logic [8:0]                           o_iteration_count
);

    localparam int CW = $clog2(ITER_LIMIT + 1);
    localparam int IW = $clog2(ITER_LIMIT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ITER = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic signed [31:0] r_zr, r_zi, r_a;
    logic [9:0]         r_x, r_y;
    logic [CW-1:0]      r_n;
    logic               r_ov;
    logic [23:0]        r_colour;
    logic [9:0]         r_ox, r_oy;
    logic [8:0]         r_ocount;

    logic signed [35:0] w_d1, w_ab1, w_d2, w_ab2;
    logic signed [31:0] w_na, w_nzi;
    logic               w_run, w_load;
    logic [23:0]        w_colour;
    logic [23:0]        w_pal [ITER_LIMIT];

    for (genvar g = 0; g < ITER_LIMIT; g++) begin : g_pal
        localparam logic [23:0] PAL_ENTRY = etff_palette(13'(g));
        assign w_pal[g] = PAL_ENTRY;
    end

    always_comb begin
        w_d1  = 36'(r_zr) - 36'(r_zi);
        w_ab1 = w_d1[35] ? -w_d1 : w_d1;
        w_na  = etff_sat36(Q_HALF - w_ab1);
        w_d2  = 36'(r_zi) + 36'(r_zr) - Q_ONE;
        w_ab2 = w_d2[35] ? -w_d2 : w_d2;
        w_nzi = etff_sat36(Q_ONE - w_ab2);
    end

    assign w_run  = (r_n < i_limit) && (r_a < ESC_LIMIT) && (r_a > -ESC_LIMIT);
    assign w_load = (r_state == ST_DONE) && (!r_ov || !i_stall);
    assign o_pop  = (r_state == ST_IDLE) && !i_q_status.empty;

    always_comb begin
        if (r_n <= CW'(8)) begin
            w_colour = COLOUR_WHITE;
        end else if (r_n >= i_limit) begin
            w_colour = COLOUR_BLACK;
        end else begin
            w_colour = w_pal[r_n[IW-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (o_pop) n_state = ST_ITER;
            ST_ITER: if (!w_run) n_state = ST_DONE;
            ST_DONE: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_zr <= i_point.zr;
            r_zi <= i_point.zi;
            r_x  <= i_point.x;
            r_y  <= i_point.y;
            r_a  <= 32'sd0;
            r_n  <= '0;
        end else if (r_state == ST_ITER && w_run) begin
            r_zr <= w_na;
            r_zi <= w_nzi;
            r_a  <= w_na;
            r_n  <= r_n + CW'(1);
        end
        if (w_load) begin
            r_colour <= w_colour;
            r_ox     <= r_x;
            r_oy     <= r_y;
            r_ocount <= 9'(r_n);
        end
    end

    assign o_valid           = r_ov;
    assign o_colour          = r_colour;
    assign o_out_x           = r_ox;
    assign o_out_y           = r_oy;
    assign o_iteration_count = r_ocount;

endmodule

// ----- src/etff_checker.sv -----
// ----------------------------------------------------------------------------
// Fold-map pixel port checker
// Watches the result channel of the top level and checks the handshake,
// the fixed colour rule for short iteration counts and the count range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "escape_time_fold_fractal_pixel_assert.svh"

module etff_checker import etff_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [23:0]          o_colour,
    input logic [9:0]           o_out_x,
    input logic [9:0]           o_out_y,
    input logic [8:0]           o_iteration_count
);

    `ETFF_ASSERT_NEXT(a_valid_held, o_out_valid && i_out_stall, o_out_valid, "result beat dropped while stalled")

    `ETFF_ASSERT_NEXT(a_beat_held, o_out_valid && i_out_stall, $stable(o_colour) && $stable(o_out_x) && $stable(o_out_y) && $stable(o_iteration_count), "result beat changed while stalled")

    `ETFF_ASSERT_NOW(a_short_white, o_out_valid && o_iteration_count <= 9'd8, o_colour == COLOUR_WHITE, "short escape is not white")

    `ETFF_ASSERT_NOW(a_count_range, o_out_valid, o_iteration_count <= 9'd256, "iteration count beyond range")

endmodule

bind escape_time_fold_fractal_pixel etff_checker u_etff_checker (.*);
